### src/blp_pkg.sv
// Shared types, request codes, constants and ramp/PWM helper functions.
`timescale 1ns / 1ps

package blp_pkg;

   localparam int REQ_W  = 3;
   localparam int DATA_W = 8;
   localparam int CSR_W  = 2;

   localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
   localparam logic [REQ_W-1:0] REQ_BREATHE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ALL_OFF   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FADE_IN   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FADE_OUT  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_STOP_MAIN = 3'd5;

   localparam logic [CSR_W-1:0] CSR_MAX_DUTY   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_PWM_PERIOD = 2'd1;
   localparam logic [CSR_W-1:0] CSR_RAMP_TICKS = 2'd2;

   localparam logic [DATA_W-1:0] MAX_DUTY_RESET   = 8'd100;
   localparam logic [DATA_W-1:0] PWM_PERIOD_RESET = 8'd100;
   localparam logic [DATA_W-1:0] RAMP_TICKS_RESET = 8'd110;

   localparam logic [DATA_W-1:0] MAIN_OFF_STEPS   = 8'd18;
   localparam logic [DATA_W-1:0] SECOND_OFF_STEPS = 8'd10;
   localparam logic [DATA_W-1:0] GRAD_TOP         = 8'd140;

   typedef struct packed {
      logic [DATA_W-1:0] max_duty;
      logic [DATA_W-1:0] pwm_period;
      logic [DATA_W-1:0] ramp_ticks;
   } cfg_type;

   typedef struct packed {
      logic              breathe_active;
      logic [DATA_W-1:0] main_count;
      logic [DATA_W-1:0] main_duty;
      logic              main_rising;
      logic [DATA_W-1:0] main_off_wait;
      logic [DATA_W-1:0] ramp_timer;
      logic              grad_active;
      logic [DATA_W-1:0] grad_count;
      logic [DATA_W-1:0] grad_duty;
      logic              second_active;
      logic [DATA_W-1:0] second_count;
      logic [DATA_W-1:0] second_duty;
      logic              second_rising;
      logic [DATA_W-1:0] second_off_wait;
      logic              main_level;
      logic              grad_level;
      logic              second_level;
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] duty;
      logic              rising;
      logic [DATA_W-1:0] off_wait;
   } ramp_type;

   typedef struct packed {
      logic [DATA_W-1:0] count;
      logic              level;
   } pwm_type;

   // One triangle ramp step: climb to the limit, fall to zero, then dwell.
   function automatic ramp_type ramp_step(input ramp_type cur,
                                          input logic [DATA_W-1:0] dwell,
                                          input logic [DATA_W-1:0] top);
      ramp_type nxt;
      nxt = cur;
      if (cur.rising) begin
         nxt.duty = cur.duty + 8'd1;
         if (nxt.duty >= top) nxt.rising = 1'b0;
      end else if (cur.duty != '0) begin
         nxt.duty     = cur.duty - 8'd1;
         nxt.off_wait = '0;
      end else begin
         nxt.off_wait = cur.off_wait + 8'd1;
         if (nxt.off_wait >= dwell) nxt.rising = 1'b1;
      end
      return nxt;
   endfunction

   // Counter beyond the period wraps to zero and the level holds, unless it is still below the duty.
   function automatic pwm_type pwm_step(input pwm_type cur,
                                        input logic [DATA_W-1:0] duty,
                                        input logic [DATA_W-1:0] top);
      pwm_type nxt;
      nxt = cur;
      if (cur.count < duty)      nxt.level = 1'b1;
      else if (cur.count <= top) nxt.level = 1'b0;
      else                       nxt.count = '0;
      return nxt;
   endfunction

endpackage

### src/blp_if.sv
// Request and response channel interfaces with valid/ready handshakes.
`timescale 1ns / 1ps

interface blp_req_if import blp_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic             use_second_channel;

   modport source(output valid, req_type, use_second_channel, input ready);
   modport sink(input valid, req_type, use_second_channel, output ready);
endinterface

interface blp_rsp_if import blp_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              main_led_on;
   logic              grad_led_on;
   logic              second_led_on;
   logic [DATA_W-1:0] main_duty_now;
   logic [DATA_W-1:0] second_duty_now;
   logic              grad_running;

   modport source(output valid, main_led_on, grad_led_on, second_led_on,
                  main_duty_now, second_duty_now, grad_running, input ready);
   modport sink(input valid, main_led_on, grad_led_on, second_led_on,
                main_duty_now, second_duty_now, grad_running, output ready);
endinterface

### src/blp_step.sv
// Next-state logic for one request item.
`timescale 1ns / 1ps

module blp_step import blp_pkg::*; (
   input  state_type        cur,
   input  cfg_type          cfg,
   input  logic [REQ_W-1:0] req_type,
   input  logic             use_second,
   output state_type        nxt
);

   ramp_type main_ramp;
   ramp_type second_ramp;
   pwm_type  main_pwm;
   pwm_type  grad_pwm;
   pwm_type  second_pwm;

   always_comb begin
      nxt         = cur;
      main_ramp   = '0;
      second_ramp = '0;
      main_pwm    = '0;
      grad_pwm    = '0;
      second_pwm  = '0;
      unique case (req_type) inside
         REQ_TICK: begin
            if (cur.breathe_active) begin
               nxt.main_count = cur.main_count + 8'd1;
               nxt.ramp_timer = cur.ramp_timer + 8'd1;
               if (nxt.ramp_timer >= cfg.ramp_ticks) begin
                  nxt.ramp_timer = '0;
                  main_ramp = ramp_step({cur.main_duty, cur.main_rising, cur.main_off_wait},
                                        MAIN_OFF_STEPS, cfg.max_duty);
                  nxt.main_duty     = main_ramp.duty;
                  nxt.main_rising   = main_ramp.rising;
                  nxt.main_off_wait = main_ramp.off_wait;
                  if (cur.grad_active) begin
                     nxt.grad_duty = cur.grad_duty + 8'd1;
                     if (nxt.grad_duty >= GRAD_TOP) nxt.grad_active = 1'b0;
                  end
                  if (cur.second_active) begin
                     second_ramp = ramp_step({cur.second_duty, cur.second_rising,
                                              cur.second_off_wait},
                                             SECOND_OFF_STEPS, cfg.max_duty);
                     nxt.second_duty     = second_ramp.duty;
                     nxt.second_rising   = second_ramp.rising;
                     nxt.second_off_wait = second_ramp.off_wait;
                  end
               end
               main_pwm = pwm_step({nxt.main_count, cur.main_level}, nxt.main_duty,
                                   cfg.pwm_period);
               nxt.main_count = main_pwm.count;
               nxt.main_level = main_pwm.level;
               // The step that finishes the fade-in skips its PWM update.
               if (nxt.grad_active) begin
                  grad_pwm = pwm_step({cur.grad_count + 8'd1, cur.grad_level},
                                      nxt.grad_duty, GRAD_TOP);
                  nxt.grad_count = grad_pwm.count;
                  nxt.grad_level = grad_pwm.level;
               end
               if (cur.second_active) begin
                  second_pwm = pwm_step({cur.second_count + 8'd1, cur.second_level},
                                        nxt.second_duty, cfg.pwm_period);
                  nxt.second_count = second_pwm.count;
                  nxt.second_level = second_pwm.level;
               end
            end
         end
         REQ_BREATHE: begin
            if (!cur.breathe_active) begin
               nxt.main_duty      = '0;
               nxt.main_rising    = 1'b1;
               nxt.main_count     = '0;
               nxt.breathe_active = 1'b1;
            end
            if (!use_second) begin
               nxt.second_active = 1'b0;
               if (!cur.grad_active) begin
                  nxt.grad_count  = '0;
                  nxt.grad_duty   = '0;
                  nxt.grad_active = 1'b1;
               end
            end else begin
               nxt.grad_active = 1'b0;
               if (!cur.second_active) begin
                  nxt.second_duty   = cfg.max_duty;
                  nxt.second_rising = 1'b0;
                  nxt.second_count  = '0;
                  nxt.second_active = 1'b1;
               end
            end
         end
         REQ_ALL_OFF: begin
            nxt.breathe_active = 1'b0;
            nxt.second_active  = 1'b0;
            nxt.grad_active    = 1'b0;
         end
         REQ_FADE_IN, REQ_FADE_OUT, REQ_STOP_MAIN: begin
            nxt.breathe_active = 1'b0;
            nxt.main_count     = '0;
            nxt.grad_count     = '0;
            nxt.second_count   = '0;
            nxt.ramp_timer     = '0;
            if (req_type == REQ_FADE_IN) begin
               nxt.main_duty      = '0;
               nxt.main_rising    = 1'b1;
               nxt.second_duty    = '0;
               nxt.second_rising  = 1'b1;
               nxt.breathe_active = 1'b1;
            end else if (req_type == REQ_FADE_OUT) begin
               nxt.main_duty      = cfg.max_duty;
               nxt.main_rising    = 1'b0;
               nxt.breathe_active = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

### src/breathing_led_pwm.sv
// Top level of the breathing LED PWM block: state, settings and response register.
// Usage:
//   Items arrive on the request channel (req_chan): a tick advances the PWM counters
//   and, when the ramp timer reaches ramp_ticks, the ramps; the other request types start, stop or fade
//   the main, fade-in and second channels. Every request item produces exactly
//   one response item on rsp_chan with the three LED levels, the main and second
//   duties and whether the fade-in is still running, all taken after the update.
//   The response is valid in the cycle after the request is accepted. Throughput
//   is one item per cycle while the receiver takes responses; the whole update is
//   one pass of increment and compare logic into the state and response registers.
//   A new request is taken whenever the response register is empty or is being
//   taken in the same cycle, so a stalled receiver holds the response and stops
//   the request channel until it drains.
//   The csr_ port writes max_duty, pwm_period and ramp_ticks by index; write only
//   while no response is outstanding. Indexes past the list are ignored.
//   Reset (synchronous, active high) stops all channels, clears counters and
//   duties, turns all outputs off, empties the response register and restores
//   the settings to 100, 100 and 110.
`timescale 1ns / 1ps

module breathing_led_pwm import blp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   blp_req_if.sink           req_chan,
   blp_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      req_take;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   blp_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .req_type   (req_chan.req_type),
      .use_second (req_chan.use_second_channel),
      .nxt        (state_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_DUTY:   cfg_in.max_duty   = csr_wdata;
            CSR_PWM_PERIOD: cfg_in.pwm_period = csr_wdata;
            CSR_RAMP_TICKS: cfg_in.ramp_ticks = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_duty   <= MAX_DUTY_RESET;
         cfg_ff.pwm_period <= PWM_PERIOD_RESET;
         cfg_ff.ramp_ticks <= RAMP_TICKS_RESET;
         state_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The response payload is the state itself, already held in registers.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.main_led_on     = state_ff.main_level;
   assign rsp_chan.grad_led_on     = state_ff.grad_level;
   assign rsp_chan.second_led_on   = state_ff.second_level;
   assign rsp_chan.main_duty_now   = state_ff.main_duty;
   assign rsp_chan.second_duty_now = state_ff.second_duty;
   assign rsp_chan.grad_running    = state_ff.grad_active;

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response register not empty after reset");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted item produced no response");

   a_all_off_stops: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.req_type == REQ_ALL_OFF) |=>
      (!state_ff.breathe_active && !state_ff.grad_active && !state_ff.second_active))
      else $error("all-off request left a channel running");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.req_type == REQ_TICK && !state_ff.breathe_active) |=>
      $stable(state_ff))
      else $error("tick changed state while stopped");
`endif

endmodule

### dv/breathing_led_pwm_tb.sv
// Self-checking testbench for the breathing LED PWM block with a ramp and PWM predictor.
`timescale 1ns / 1ps

module breathing_led_pwm_tb;
   import blp_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;
   localparam logic [CSR_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 6;

   typedef struct packed {
      logic              main_on;
      logic              grad_on;
      logic              second_on;
      logic [DATA_W-1:0] main_duty;
      logic [DATA_W-1:0] second_duty;
      logic              grad_running;
   } led_levels_type;

   // Tracks the three LED channels and holds the levels still owed by the block.
   class led_scoreboard_type;
      logic [DATA_W-1:0] max_duty, pwm_period, ramp_ticks;
      logic              running, main_up, grad_act, second_act, second_up;
      logic [DATA_W-1:0] main_cnt, main_duty, main_dwell, ramp_cnt;
      logic [DATA_W-1:0] grad_cnt, grad_duty;
      logic [DATA_W-1:0] second_cnt, second_duty, second_dwell;
      logic [2:0]        levels;
      led_levels_type    pending_levels[$];
      int                errors;

      function new();
         max_duty     = MAX_DUTY_RESET;
         pwm_period   = PWM_PERIOD_RESET;
         ramp_ticks   = RAMP_TICKS_RESET;
         running      = 1'b0;
         main_up      = 1'b0;
         grad_act     = 1'b0;
         second_act   = 1'b0;
         second_up    = 1'b0;
         main_cnt     = '0;
         main_duty    = '0;
         main_dwell   = '0;
         ramp_cnt     = '0;
         grad_cnt     = '0;
         grad_duty    = '0;
         second_cnt   = '0;
         second_duty  = '0;
         second_dwell = '0;
         levels       = '0;
         errors       = 0;
      endfunction

      function void set_register(logic [CSR_W-1:0] index, logic [DATA_W-1:0] value);
         case (index)
            CSR_MAX_DUTY:   max_duty   = value;
            CSR_PWM_PERIOD: pwm_period = value;
            CSR_RAMP_TICKS: ramp_ticks = value;
            default: ;
         endcase
      endfunction

      function void ramp(inout logic [DATA_W-1:0] duty, inout logic up,
                         inout logic [DATA_W-1:0] dwell_cnt, input logic [DATA_W-1:0] dwell);
         if (up) begin
            duty = duty + 8'd1;
            if (duty >= max_duty) up = 1'b0;
         end else if (duty != '0) begin
            duty      = duty - 8'd1;
            dwell_cnt = '0;
         end else begin
            dwell_cnt = dwell_cnt + 8'd1;
            if (dwell_cnt >= dwell) up = 1'b1;
         end
      endfunction

      // Past the period the counter wraps and the output level is left alone, unless it is still below the duty.
      function void pwm(inout logic [DATA_W-1:0] cnt, input logic [DATA_W-1:0] duty,
                        input logic [DATA_W-1:0] top, input logic [1:0] lane);
         if (cnt < duty) levels[lane] = 1'b1;
         else if (cnt <= top) levels[lane] = 1'b0;
         else cnt = '0;
      endfunction

      function void advance_tick();
         if (!running) return;
         main_cnt = main_cnt + 8'd1;
         ramp_cnt = ramp_cnt + 8'd1;
         if (ramp_cnt >= ramp_ticks) begin
            ramp_cnt = '0;
            ramp(main_duty, main_up, main_dwell, MAIN_OFF_STEPS);
            if (grad_act) begin
               grad_duty = grad_duty + 8'd1;
               if (grad_duty >= GRAD_TOP) grad_act = 1'b0;
            end
            if (second_act) ramp(second_duty, second_up, second_dwell, SECOND_OFF_STEPS);
         end
         pwm(main_cnt, main_duty, pwm_period, 2'd0);
         if (grad_act) begin
            grad_cnt = grad_cnt + 8'd1;
            pwm(grad_cnt, grad_duty, GRAD_TOP, 2'd1);
         end
         if (second_act) begin
            second_cnt = second_cnt + 8'd1;
            pwm(second_cnt, second_duty, pwm_period, 2'd2);
         end
      endfunction

      function void start_breathing(logic use_second);
         if (!running) begin
            main_duty = '0;
            main_up   = 1'b1;
            main_cnt  = '0;
            running   = 1'b1;
         end
         if (!use_second) begin
            second_act = 1'b0;
            if (!grad_act) begin
               grad_cnt  = '0;
               grad_duty = '0;
               grad_act  = 1'b1;
            end
         end else begin
            grad_act = 1'b0;
            if (!second_act) begin
               second_duty = max_duty;
               second_up   = 1'b0;
               second_cnt  = '0;
               second_act  = 1'b1;
            end
         end
      endfunction

      // Fade in, fade out and stop main all restart the counters; dwell counts survive.
      function void change_mode(logic [REQ_W-1:0] rtype);
         running    = 1'b0;
         main_cnt   = '0;
         grad_cnt   = '0;
         second_cnt = '0;
         ramp_cnt   = '0;
         if (rtype == REQ_FADE_IN) begin
            main_duty   = '0;
            main_up     = 1'b1;
            second_duty = '0;
            second_up   = 1'b1;
            running     = 1'b1;
         end else if (rtype == REQ_FADE_OUT) begin
            main_duty = max_duty;
            main_up   = 1'b0;
            running   = 1'b1;
         end
      endfunction

      function void apply_request(logic [REQ_W-1:0] rtype, logic use_second);
         led_levels_type lv;
         case (rtype) inside
            REQ_TICK:    advance_tick();
            REQ_BREATHE: start_breathing(use_second);
            REQ_ALL_OFF: begin
               running    = 1'b0;
               second_act = 1'b0;
               grad_act   = 1'b0;
            end
            REQ_FADE_IN, REQ_FADE_OUT, REQ_STOP_MAIN: change_mode(rtype);
            default: ;
         endcase
         lv.main_on      = levels[0];
         lv.grad_on      = levels[1];
         lv.second_on    = levels[2];
         lv.main_duty    = main_duty;
         lv.second_duty  = second_duty;
         lv.grad_running = grad_act;
         pending_levels.push_back(lv);
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_levels(led_levels_type got);
         led_levels_type want;
         if (pending_levels.size() == 0) begin
            report("response item arrived with nothing outstanding");
            return;
         end
         want = pending_levels.pop_front();
         compare_field("main_led_on", DATA_W'(got.main_on), DATA_W'(want.main_on));
         compare_field("grad_led_on", DATA_W'(got.grad_on), DATA_W'(want.grad_on));
         compare_field("second_led_on", DATA_W'(got.second_on), DATA_W'(want.second_on));
         compare_field("main_duty_now", got.main_duty, want.main_duty);
         compare_field("second_duty_now", got.second_duty, want.second_duty);
         compare_field("grad_running", DATA_W'(got.grad_running),
                       DATA_W'(want.grad_running));
      endtask
   endclass

   logic clock;
   logic reset;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [DATA_W-1:0] csr_wdata;

   blp_req_if req_chan();
   blp_rsp_if rsp_chan();

   breathing_led_pwm uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   led_scoreboard_type levels_sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin : rsp_monitor
      led_levels_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.main_on      = rsp_chan.main_led_on;
         got.grad_on      = rsp_chan.grad_led_on;
         got.second_on    = rsp_chan.second_led_on;
         got.main_duty    = rsp_chan.main_duty_now;
         got.second_duty  = rsp_chan.second_duty_now;
         got.grad_running = rsp_chan.grad_running;
         levels_sb.check_levels(got);
      end
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic drive_request(input logic [REQ_W-1:0] rtype, input logic use_second);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.req_type           <= rtype;
      req_chan.use_second_channel <= use_second;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      levels_sb.apply_request(rtype, use_second);
   endtask

   task automatic write_register(input logic [CSR_W-1:0] index, input logic [DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      levels_sb.set_register(index, value);
   endtask

   // Every item yields a response, so a short settle after the last one is enough.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (levels_sb.pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly a command followed by a run of ticks, so ramps get time to develop.
   task automatic random_items(input int count);
      int sent;
      int pick;
      int run;
      logic [REQ_W-1:0] cmd;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) cmd = REQ_BREATHE;
         else if (pick < 52) cmd = REQ_FADE_IN;
         else if (pick < 64) cmd = REQ_FADE_OUT;
         else if (pick < 74) cmd = REQ_STOP_MAIN;
         else if (pick < 86) cmd = REQ_ALL_OFF;
         else if (pick < 89) cmd = REQ_UNUSED_A;
         else if (pick < 92) cmd = REQ_UNUSED_B;
         else cmd = REQ_TICK;
         drive_request(cmd, 1'($urandom_range(0, 1)));
         sent++;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 40);
         for (int i = 0; i < run && sent < count; i++) begin
            drive_request(REQ_TICK, 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   logic [DATA_W-1:0] phase_max[NUM_PHASES]    = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd6, 8'd12};
   logic [DATA_W-1:0] phase_period[NUM_PHASES] = '{8'd4, 8'd1, 8'd255, 8'd0, 8'd9, 8'd30};
   logic [DATA_W-1:0] phase_ramp[NUM_PHASES]   = '{8'd1, 8'd0, 8'd1, 8'd2, 8'd255, 8'd3};
   int phase_items[NUM_PHASES]                 = '{130, 90, 260, 110, 100, 110};
   int idle_send[4]  = '{0, 79, 0, 25};
   int idle_recv[4]  = '{0, 0, 79, 25};

   initial begin
      levels_sb = new();
      reset                       <= 1'b1;
      req_chan.valid              <= 1'b0;
      req_chan.req_type           <= REQ_TICK;
      req_chan.use_second_channel <= 1'b0;
      csr_we                      <= 1'b0;
      csr_index                   <= CSR_MAX_DUTY;
      csr_wdata                   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset settings.
      drive_request(REQ_TICK, 1'b0);
      drive_request(REQ_UNUSED_A, 1'b0);
      drive_request(REQ_UNUSED_B, 1'b1);
      drive_request(REQ_BREATHE, 1'b0);
      repeat (3) drive_request(REQ_TICK, 1'b1);
      drive_request(REQ_BREATHE, 1'b0);
      drive_request(REQ_BREATHE, 1'b1);
      repeat (2) drive_request(REQ_TICK, 1'b0);
      drive_request(REQ_BREATHE, 1'b1);
      drive_request(REQ_FADE_IN, 1'b0);
      drive_request(REQ_FADE_IN, 1'b1);
      drive_request(REQ_TICK, 1'b0);
      drive_request(REQ_FADE_OUT, 1'b0);
      drive_request(REQ_TICK, 1'b0);
      drive_request(REQ_STOP_MAIN, 1'b1);
      drive_request(REQ_STOP_MAIN, 1'b0);
      drive_request(REQ_TICK, 1'b0);
      drive_request(REQ_ALL_OFF, 1'b0);
      drive_request(REQ_TICK, 1'b1);
      drive_request(REQ_BREATHE, 1'b1);
      drive_request(REQ_ALL_OFF, 1'b1);
      drive_request(REQ_TICK, 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_responses();
         write_register(CSR_MAX_DUTY, phase_max[p]);
         write_register(CSR_PWM_PERIOD, phase_period[p]);
         write_register(CSR_RAMP_TICKS, phase_ramp[p]);
         if (p == 0) write_register(CSR_UNUSED, DATA_W'($urandom_range(0, 255)));
         csr_we <= 1'b0;
         send_idle_pct  = idle_send[p % 4];
         recv_stall_pct = idle_recv[p % 4];
         random_items(phase_items[p]);
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (levels_sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
